>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the scaler block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define PNNS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("pnns assertion failed");
// Check that a condition never holds outside reset.
`define PNNS_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("pnns forbidden condition");
`else
`define PNNS_ASSERT(lbl, clk, rstn, prop)
`define PNNS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/pnns_pkg.sv
// Package of the scaler block: sizes, codes, payload types and sequencer states.
package pnns_pkg;

	localparam int SRC_PITCH   = 256;
	localparam int FRAME_ROWS  = 240;
	localparam int FRAME_DEPTH = SRC_PITCH * FRAME_ROWS;
	localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
	localparam int PANEL_W     = 320;
	localparam int PANEL_H     = 240;
	localparam int PAL_SIZE    = 256;
	localparam int PCT         = 100;
	localparam int FIT_NUM_W   = PANEL_W * PCT;
	localparam int FIT_NUM_H   = PANEL_H * PCT;
	// Shared divider: dividend, quotient and divisor widths.
	localparam int DIV_W       = 17;
	localparam int DEN_W       = 9;
	localparam int DIV_CW      = 5;
	localparam int SCALE_W     = 15;
	// Divide by PCT as a multiply by ceil(2^19 / 100) and a shift;
	// exact for dividends below 43500, the fit products stay under 32001.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SH    = 19;
	localparam int MUL_W       = DIV_W + RECIP_W;
	localparam int PCTQ_W      = MUL_W - RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP_PCT = 13'd5243;

	localparam logic [1:0] REG_SCALE_MODE  = 2'd0;
	localparam logic [1:0] REG_VIEW_X      = 2'd1;
	localparam logic [1:0] REG_VIEW_WIDTH  = 2'd2;
	localparam logic [1:0] REG_VIEW_HEIGHT = 2'd3;

	localparam logic [1:0] MODE_NATIVE  = 2'd1;
	localparam logic [1:0] MODE_STRETCH = 2'd2;

	localparam logic [1:0] CMD_PAL_WRITE = 2'd0;
	localparam logic [1:0] CMD_PIX_WRITE = 2'd1;
	localparam logic [1:0] CMD_FETCH     = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  palette_slot;
		logic [15:0] palette_color;
		logic [7:0]  src_col;
		logic [7:0]  src_row;
		logic [7:0]  src_index;
		logic [8:0]  out_col;
		logic [7:0]  out_row;
	} in_t;

	typedef struct packed {
		logic [15:0] pixel_rgb;
		logic        in_range;
		logic [8:0]  out_width;
		logic [7:0]  out_height;
	} out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SZ_X,
		ST_SZ_Y,
		ST_SZ_M,
		ST_SZ_W,
		ST_SZ_H,
		ST_FX,
		ST_FY,
		ST_READ,
		ST_PAL,
		ST_OUT
	} state_t;

endpackage

>>> hw/rtl/pnns_if.sv
// Request channels of the scaler block: input items and result items.
interface pnns_in_if;
	logic           valid;
	logic           ready;
	pnns_pkg::in_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pnns_out_if;
	logic           valid;
	logic           ready;
	pnns_pkg::out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/palette_nearest_neighbor_scaler_unit.sv
// Top level: indexed frame store, palette and nearest-neighbor output fetch.
// Usage:
// in_ch carries requests: palette write, source pixel write or pixel fetch.
// out_ch returns one result for each fetch: color, in-range flag, output size.
// cfg_we/cfg_idx/cfg_wdata write scale mode, window x, width and height.
// Writes are stored as they are accepted and leave the sequencer idle. A
// fetch inside the output runs from acceptance to result through two 17-step
// divisions on the shared divider, one frame store read and one palette read;
// a fetch outside the output goes straight to the output state. One request
// is worked on at a time; the next is taken when the sequencer returns to idle.
// After a configuration write the output size is recomputed: directly for
// native or stretch; for fit mode by two divisions, two multiplies by the
// scale, two reciprocal multiplies by 1/100 and a clamp; requests wait meanwhile.
// After reset the frame store is swept to zero, all 61440 entries, one entry a
// cycle; no request is accepted during the sweep, configuration writes are.
// The palette holds no defined value until written.
// When out_ch stalls, a finished result waits in the output register;
// requests are still accepted, but a further fetch holds its result, and the
// input, until the waiting one leaves.
`include "assert_macros.svh"
module palette_nearest_neighbor_scaler_unit (
	input  logic             clk,
	input  logic             arst_n,
	pnns_in_if.sink          in_ch,
	pnns_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [8:0]       cfg_wdata
);

	// Configuration and derived size
	logic [1:0] scale_mode_q;
	logic [7:0] view_x_q;
	logic [8:0] view_width_q;
	logic [7:0] view_height_q;
	logic       recalc_q;
	logic [8:0] sc_w_q;
	logic [7:0] sc_h_q;

	pnns_pkg::state_t state_q, state_d;

	// Divider
	logic [pnns_pkg::DIV_W-1:0]  quo_q;
	logic [pnns_pkg::DEN_W:0]    rem_q;
	logic [pnns_pkg::DEN_W-1:0]  den_q;
	logic [pnns_pkg::DIV_CW-1:0] div_cnt_q;
	logic                        div_load;
	logic [pnns_pkg::DIV_W-1:0]  div_num;
	logic [pnns_pkg::DEN_W-1:0]  div_den;
	logic                        div_done;
	logic [pnns_pkg::DEN_W:0]    trial;

	// Work registers
	logic [pnns_pkg::SCALE_W-1:0] sx_q;
	logic [pnns_pkg::SCALE_W-1:0] s_q;
	logic [pnns_pkg::DIV_W-1:0]   ws_q;
	logic [pnns_pkg::DIV_W-1:0]   hs_q;
	logic [pnns_pkg::PCTQ_W-1:0]  sw_raw_q;
	logic [pnns_pkg::PCTQ_W-1:0]  sh_raw_q;
	logic [7:0]                   oy_q;
	logic                         hit_q;
	logic [7:0]                   fx_q;
	logic [7:0]                   fy_q;
	logic                         addr_ok_q;

	// Memories
	logic [7:0]  frame_mem [pnns_pkg::FRAME_DEPTH];
	logic [15:0] pal_mem [pnns_pkg::PAL_SIZE];
	logic [7:0]  fb_rd_q;
	logic [15:0] pal_rd_q;
	logic [pnns_pkg::FRAME_AW-1:0] clr_cnt_q;
	logic                          fb_we;
	logic [pnns_pkg::FRAME_AW-1:0] fb_wa;
	logic [7:0]                    fb_wd;
	logic [pnns_pkg::FRAME_AW-1:0] fb_ra;
	logic [16:0]                   rd_addr;

	logic         out_valid_q;
	pnns_pkg::out_t out_q;
	logic         out_free;
	logic         in_fire;
	pnns_pkg::in_t req;

	// Clamped window
	logic [8:0] w0;
	logic [9:0] x_plus_w;
	logic [7:0] win_x;
	logic [8:0] win_w;
	logic [7:0] win_h;
	logic       req_hit;
	logic [pnns_pkg::SCALE_W-1:0] s_min;
	logic [23:0] prod_ws;
	logic [22:0] prod_hs;
	logic [17:0] prod_fx;
	logic [15:0] prod_fy;
	logic [pnns_pkg::MUL_W-1:0] sw_mul;
	logic [pnns_pkg::MUL_W-1:0] sh_mul;

	assign req      = in_ch.payload;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == pnns_pkg::ST_IDLE) && !recalc_q;
	assign in_fire  = in_ch.valid && in_ch.ready;

	// Clamp the viewport to the frame
	always_comb begin
		win_x    = view_x_q;
		w0       = (view_width_q == 9'd0) ? 9'(pnns_pkg::SRC_PITCH) : view_width_q;
		x_plus_w = {1'b0, w0} + {2'b00, view_x_q};
		if (x_plus_w > 10'(pnns_pkg::SRC_PITCH))
			win_w = 9'(10'(pnns_pkg::SRC_PITCH) - {2'b00, view_x_q});
		else
			win_w = w0;
		if (view_height_q == 8'd0 || view_height_q > 8'(pnns_pkg::FRAME_ROWS))
			win_h = 8'(pnns_pkg::FRAME_ROWS);
		else
			win_h = view_height_q;
	end

	assign req_hit = (req.out_col < sc_w_q) && (req.out_row < sc_h_q);
	assign s_min   = (sx_q < quo_q[pnns_pkg::SCALE_W-1:0]) ? sx_q
		: quo_q[pnns_pkg::SCALE_W-1:0];
	assign prod_ws = win_w * s_q;
	assign prod_hs = win_h * s_q;
	assign prod_fx = req.out_col * win_w;
	assign prod_fy = oy_q * win_h;
	assign sw_mul  = ws_q * pnns_pkg::RECIP_PCT;
	assign sh_mul  = hs_q * pnns_pkg::RECIP_PCT;
	assign div_done = (div_cnt_q == '0);
	assign trial    = {rem_q[pnns_pkg::DEN_W-1:0], quo_q[pnns_pkg::DIV_W-1]};
	assign rd_addr  = {1'b0, fy_q, 8'h00} + {9'd0, win_x} + {9'd0, fx_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q  <= 2'd0;
			view_x_q      <= 8'd0;
			view_width_q  <= 9'd160;
			view_height_q <= 8'd144;
		end else if (cfg_we) begin
			case (cfg_idx)
				pnns_pkg::REG_SCALE_MODE:  scale_mode_q  <= cfg_wdata[1:0];
				pnns_pkg::REG_VIEW_X:      view_x_q      <= cfg_wdata[7:0];
				pnns_pkg::REG_VIEW_WIDTH:  view_width_q  <= cfg_wdata;
				pnns_pkg::REG_VIEW_HEIGHT: view_height_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pnns_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	// Next state and divider loads
	always_comb begin
		state_d  = state_q;
		div_load = 1'b0;
		div_num  = '0;
		div_den  = '0;
		case (state_q)
			pnns_pkg::ST_CLEAR: begin
				if (clr_cnt_q == pnns_pkg::FRAME_AW'(pnns_pkg::FRAME_DEPTH - 1))
					state_d = pnns_pkg::ST_IDLE;
			end
			pnns_pkg::ST_IDLE: begin
				if (recalc_q) begin
					if (scale_mode_q != pnns_pkg::MODE_NATIVE
						&& scale_mode_q != pnns_pkg::MODE_STRETCH) begin
						div_load = 1'b1;
						div_num  = pnns_pkg::DIV_W'(pnns_pkg::FIT_NUM_W);
						div_den  = win_w;
						state_d  = pnns_pkg::ST_SZ_X;
					end
				end else if (in_fire && req.cmd == pnns_pkg::CMD_FETCH) begin
					if (req_hit) begin
						div_load = 1'b1;
						div_num  = prod_fx[pnns_pkg::DIV_W-1:0];
						div_den  = sc_w_q;
						state_d  = pnns_pkg::ST_FX;
					end else begin
						state_d = pnns_pkg::ST_OUT;
					end
				end
			end
			pnns_pkg::ST_SZ_X: begin
				if (div_done) begin
					div_load = 1'b1;
					div_num  = pnns_pkg::DIV_W'(pnns_pkg::FIT_NUM_H);
					div_den  = {1'b0, win_h};
					state_d  = pnns_pkg::ST_SZ_Y;
				end
			end
			pnns_pkg::ST_SZ_Y: begin
				if (div_done)
					state_d = pnns_pkg::ST_SZ_M;
			end
			pnns_pkg::ST_SZ_M: state_d = pnns_pkg::ST_SZ_W;
			pnns_pkg::ST_SZ_W: state_d = pnns_pkg::ST_SZ_H;
			pnns_pkg::ST_SZ_H: state_d = pnns_pkg::ST_IDLE;
			pnns_pkg::ST_FX: begin
				if (div_done) begin
					div_load = 1'b1;
					div_num  = {1'b0, prod_fy};
					div_den  = {1'b0, sc_h_q};
					state_d  = pnns_pkg::ST_FY;
				end
			end
			pnns_pkg::ST_FY: begin
				if (div_done)
					state_d = pnns_pkg::ST_READ;
			end
			pnns_pkg::ST_READ: state_d = pnns_pkg::ST_PAL;
			pnns_pkg::ST_PAL:  state_d = pnns_pkg::ST_OUT;
			pnns_pkg::ST_OUT: begin
				if (out_free)
					state_d = pnns_pkg::ST_IDLE;
			end
			default: state_d = pnns_pkg::ST_IDLE;
		endcase
	end

	// Shared restoring divider, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_load) begin
			div_cnt_q <= pnns_pkg::DIV_CW'(pnns_pkg::DIV_W);
		end else if (!div_done) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			quo_q <= div_num;
			rem_q <= '0;
			den_q <= div_den;
		end else if (!div_done) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[pnns_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[pnns_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	// Size recompute request and scaled size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recalc_q <= 1'b1;
			sc_w_q   <= 9'd265;
			sc_h_q   <= 8'd239;
		end else begin
			if (cfg_we)
				recalc_q <= 1'b1;
			else if (state_q == pnns_pkg::ST_IDLE)
				recalc_q <= 1'b0;
			if (state_q == pnns_pkg::ST_IDLE && recalc_q) begin
				if (scale_mode_q == pnns_pkg::MODE_NATIVE) begin
					sc_w_q <= win_w;
					sc_h_q <= win_h;
				end else if (scale_mode_q == pnns_pkg::MODE_STRETCH) begin
					sc_w_q <= 9'(pnns_pkg::PANEL_W);
					sc_h_q <= 8'(pnns_pkg::PANEL_H);
				end
			end
			if (state_q == pnns_pkg::ST_SZ_H) begin
				if (sw_raw_q > pnns_pkg::PCTQ_W'(pnns_pkg::PANEL_W))
					sc_w_q <= 9'(pnns_pkg::PANEL_W);
				else if (sw_raw_q == '0)
					sc_w_q <= 9'd1;
				else
					sc_w_q <= sw_raw_q[8:0];
				if (sh_raw_q > pnns_pkg::PCTQ_W'(pnns_pkg::PANEL_H))
					sc_h_q <= 8'(pnns_pkg::PANEL_H);
				else if (sh_raw_q == '0)
					sc_h_q <= 8'd1;
				else
					sc_h_q <= sh_raw_q[7:0];
			end
		end
	end

	// Capture intermediate results
	always_ff @(posedge clk) begin
		if (state_q == pnns_pkg::ST_SZ_X && div_done)
			sx_q <= quo_q[pnns_pkg::SCALE_W-1:0];
		if (state_q == pnns_pkg::ST_SZ_Y && div_done)
			s_q <= s_min;
		if (state_q == pnns_pkg::ST_SZ_M) begin
			ws_q <= prod_ws[pnns_pkg::DIV_W-1:0];
			hs_q <= prod_hs[pnns_pkg::DIV_W-1:0];
		end
		if (state_q == pnns_pkg::ST_SZ_W) begin
			sw_raw_q <= sw_mul[pnns_pkg::RECIP_SH +: pnns_pkg::PCTQ_W];
			sh_raw_q <= sh_mul[pnns_pkg::RECIP_SH +: pnns_pkg::PCTQ_W];
		end
		if (in_fire) begin
			oy_q  <= req.out_row;
			hit_q <= req_hit;
		end
		if (state_q == pnns_pkg::ST_FX && div_done)
			fx_q <= quo_q[7:0];
		if (state_q == pnns_pkg::ST_FY && div_done)
			fy_q <= quo_q[7:0];
		if (state_q == pnns_pkg::ST_READ)
			addr_ok_q <= (rd_addr < 17'(pnns_pkg::FRAME_DEPTH));
	end

	// Clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (state_q == pnns_pkg::ST_CLEAR)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// Frame store port selection
	always_comb begin
		fb_ra = rd_addr[pnns_pkg::FRAME_AW-1:0];
		if (state_q == pnns_pkg::ST_CLEAR) begin
			fb_we = 1'b1;
			fb_wa = clr_cnt_q;
			fb_wd = 8'd0;
		end else begin
			fb_we = in_fire && req.cmd == pnns_pkg::CMD_PIX_WRITE
				&& req.src_row < 8'(pnns_pkg::FRAME_ROWS);
			fb_wa = {req.src_row, req.src_col};
			fb_wd = req.src_index;
		end
	end

	// Frame store memory
	always_ff @(posedge clk) begin
		if (fb_we)
			frame_mem[fb_wa] <= fb_wd;
		fb_rd_q <= frame_mem[fb_ra];
	end

	// Palette memory
	always_ff @(posedge clk) begin
		if (in_fire && req.cmd == pnns_pkg::CMD_PAL_WRITE)
			pal_mem[req.palette_slot] <= req.palette_color;
		pal_rd_q <= pal_mem[fb_rd_q];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == pnns_pkg::ST_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == pnns_pkg::ST_OUT && out_free) begin
			out_q.pixel_rgb  <= (hit_q && addr_ok_q) ? pal_rd_q : 16'd0;
			out_q.in_range   <= hit_q;
			out_q.out_width  <= sc_w_q;
			out_q.out_height <= sc_h_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	`PNNS_NEVER(a_size_range, clk, arst_n,
		sc_w_q == 9'd0 || sc_w_q > 9'(pnns_pkg::PANEL_W) || sc_h_q == 8'd0
		|| sc_h_q > 8'(pnns_pkg::PANEL_H))
	`PNNS_NEVER(a_div_idle, clk, arst_n,
		!div_done && (state_q == pnns_pkg::ST_IDLE || state_q == pnns_pkg::ST_OUT))
	`PNNS_ASSERT(a_pal_to_out, clk, arst_n,
		state_q == pnns_pkg::ST_PAL |=> state_q == pnns_pkg::ST_OUT)
	`PNNS_ASSERT(a_miss_fast, clk, arst_n,
		in_fire && req.cmd == pnns_pkg::CMD_FETCH && !req_hit |=> state_q == pnns_pkg::ST_OUT)

endmodule

>>> sim/palette_nearest_neighbor_scaler_unit_tb.sv
// Testbench of the palette scaler: directed table, random requests, color predictor.
module palette_nearest_neighbor_scaler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT  = 1000000;
	localparam int SETTLE     = 120;
	localparam int PER_VIEW   = 114;
	localparam logic [1:0] CMD_NOP = 2'd3;

	typedef struct {
		pnns_pkg::in_t  req;
		bit             typed;
		pnns_pkg::out_t want;
	} dir_row_t;

	typedef struct {
		logic [8:0] mode;
		logic [8:0] vx;
		logic [8:0] vw;
		logic [8:0] vh;
	} view_cfg_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [8:0] cfg_wdata;

	pnns_in_if  req_ch ();
	pnns_out_if pix_ch ();

	palette_nearest_neighbor_scaler_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (req_ch),
		.out_ch    (pix_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state: frame, palette, registers, clamped window and size
	logic [7:0]  frame_mem [pnns_pkg::FRAME_DEPTH];
	logic [15:0] pal_mem [pnns_pkg::PAL_SIZE];
	int unsigned mode_reg, vx_reg, vw_reg, vh_reg;
	int unsigned win_x, win_w, win_h, size_w, size_h;

	pnns_pkg::out_t pending_pixels [$];
	int   mismatches;
	int   checked;
	int   cycles;
	bit   no_idle;
	bit   long_hold;

	always #4 clk = ~clk;

	// Recompute window and output size from the registers
	function automatic void resize_output();
		int unsigned x, w, h, fx, fy, s;
		x = vx_reg;
		w = vw_reg;
		h = vh_reg;
		if (x >= pnns_pkg::SRC_PITCH) x = 0;
		if (w < 1) w = pnns_pkg::SRC_PITCH;
		if (x + w > pnns_pkg::SRC_PITCH) w = pnns_pkg::SRC_PITCH - x;
		if (h < 1 || h > pnns_pkg::FRAME_ROWS) h = pnns_pkg::FRAME_ROWS;
		win_x = x;
		win_w = w;
		win_h = h;
		if (mode_reg == pnns_pkg::MODE_NATIVE) begin
			size_w = w;
			size_h = h;
		end else if (mode_reg == pnns_pkg::MODE_STRETCH) begin
			size_w = pnns_pkg::PANEL_W;
			size_h = pnns_pkg::PANEL_H;
		end else begin
			fx = pnns_pkg::PANEL_W * pnns_pkg::PCT / w;
			fy = pnns_pkg::PANEL_H * pnns_pkg::PCT / h;
			s = (fx < fy) ? fx : fy;
			size_w = w * s / pnns_pkg::PCT;
			size_h = h * s / pnns_pkg::PCT;
		end
		if (size_w > pnns_pkg::PANEL_W) size_w = pnns_pkg::PANEL_W;
		if (size_h > pnns_pkg::PANEL_H) size_h = pnns_pkg::PANEL_H;
		if (size_w < 1) size_w = 1;
		if (size_h < 1) size_h = 1;
	endfunction

	// Apply one accepted request; return 1 with the pixel when it is a fetch
	function automatic bit predict_pixel(input pnns_pkg::in_t r, output pnns_pkg::out_t px);
		int unsigned sx, sy, addr;
		px = '0;
		case (r.cmd)
			pnns_pkg::CMD_PAL_WRITE: begin
				pal_mem[r.palette_slot] = r.palette_color;
				return 0;
			end
			pnns_pkg::CMD_PIX_WRITE: begin
				if (r.src_row < pnns_pkg::FRAME_ROWS)
					frame_mem[r.src_row * pnns_pkg::SRC_PITCH + r.src_col] = r.src_index;
				return 0;
			end
			pnns_pkg::CMD_FETCH: begin
				px.in_range = (r.out_col < size_w) && (r.out_row < size_h);
				if (px.in_range) begin
					sx = r.out_col * win_w / size_w;
					sy = r.out_row * win_h / size_h;
					addr = sy * pnns_pkg::SRC_PITCH + win_x + sx;
					if (addr < pnns_pkg::FRAME_DEPTH)
						px.pixel_rgb = pal_mem[frame_mem[addr]];
				end
				px.out_width = size_w[8:0];
				px.out_height = size_h[7:0];
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// Offer one request after a random gap; hold valid across back-to-back requests
	task automatic send_req(input pnns_pkg::in_t r, input bit typed,
			input pnns_pkg::out_t want);
		int gap;
		pnns_pkg::out_t px;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		if (predict_pixel(r, px)) pending_pixels.push_back(typed ? want : px);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	// Wait until every fetch has returned, then let the sequencer settle
	task automatic drain();
		stop_requests();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all four registers on consecutive cycles
	task automatic write_view(input view_cfg_t c);
		logic [8:0] vals [4];
		vals = '{c.mode, c.vx, c.vw, c.vh};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= i[1:0];
			cfg_wdata <= vals[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_reg = c.mode[1:0];
		vx_reg = c.vx[7:0];
		vw_reg = c.vw;
		vh_reg = c.vh[7:0];
		resize_output();
	endtask

	function automatic pnns_pkg::in_t rand_req();
		pnns_pkg::in_t r;
		int unsigned pick;
		r = '0;
		r.palette_slot = 8'($urandom_range(0, 255));
		r.palette_color = 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 15) r.cmd = pnns_pkg::CMD_PAL_WRITE;
		else if (pick < 45) r.cmd = pnns_pkg::CMD_PIX_WRITE;
		else if (pick < 96) r.cmd = pnns_pkg::CMD_FETCH;
		else r.cmd = CMD_NOP;
		// Mostly land inside the window, sometimes anywhere the field allows
		if ($urandom_range(0, 3) != 0) begin
			r.src_col = 8'(win_x + $urandom_range(0, win_w - 1));
			r.src_row = 8'($urandom_range(0, win_h - 1));
		end else begin
			r.src_col = 8'($urandom_range(0, 255));
			r.src_row = 8'($urandom_range(0, 255));
		end
		r.src_index = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 4) != 0) begin
			r.out_col = 9'($urandom_range(0, size_w - 1));
			r.out_row = 8'($urandom_range(0, size_h - 1));
		end else begin
			r.out_col = 9'($urandom_range(0, 511));
			r.out_row = 8'($urandom_range(0, 255));
		end
		return r;
	endfunction

	// Result side: random stalls per result, one long hold-off on request
	initial begin
		int n;
		pix_ch.ready = 1'b0;
		forever begin
			if (long_hold) begin
				@(negedge clk);
				pix_ch.ready <= 1'b0;
				repeat (600) @(negedge clk);
				long_hold = 0;
			end
			n = no_idle ? 0 : $urandom_range(0, 11);
			if (n > 0) begin
				@(negedge clk);
				pix_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			pix_ch.ready <= 1'b1;
			do @(posedge clk); while (!pix_ch.valid);
		end
	end

	// Compare each returned pixel with the oldest expectation
	always @(posedge clk) begin
		pnns_pkg::out_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel result %p", pix_ch.payload);
			end else begin
				want = pending_pixels.pop_front();
				checked++;
				if (pix_ch.payload.pixel_rgb !== want.pixel_rgb
						|| pix_ch.payload.in_range !== want.in_range
						|| pix_ch.payload.out_width !== want.out_width
						|| pix_ch.payload.out_height !== want.out_height) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: expected %p, got %p", want,
							pix_ch.payload);
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		dir_row_t       dir_rows [$];
		view_cfg_t      views [$];
		dir_row_t       row;
		pnns_pkg::in_t  r;
		pnns_pkg::out_t off_reset;
		int             sent;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		mismatches = 0;
		checked = 0;
		cycles = 0;
		no_idle = 0;
		long_hold = 0;
		sent = 0;
		foreach (frame_mem[i]) frame_mem[i] = '0;
		foreach (pal_mem[i]) pal_mem[i] = '0;
		mode_reg = 0;
		vx_reg = 0;
		vw_reg = 160;
		vh_reg = 144;
		resize_output();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole palette so no fetch reads an unwritten entry
		for (int i = 0; i < pnns_pkg::PAL_SIZE; i++) begin
			r = '0;
			r.cmd = pnns_pkg::CMD_PAL_WRITE;
			r.palette_slot = 8'(i);
			r.palette_color = 16'($urandom_range(0, 65535));
			send_req(r, 0, '0);
		end

		// Directed table under the reset window: size 265 x 239
		off_reset = '{pixel_rgb: 16'h0, in_range: 1'b0, out_width: 9'd265,
			out_height: 8'd239};
		r = '0; r.cmd = pnns_pkg::CMD_FETCH;
		row = '{r, 0, '0};                                     dir_rows.push_back(row);
		r.out_col = 9'd264; r.out_row = 8'd238; row.req = r;   dir_rows.push_back(row);
		row.typed = 1; row.want = off_reset;
		r.out_col = 9'd265; r.out_row = 8'd0; row.req = r;     dir_rows.push_back(row);
		r.out_col = 9'd0; r.out_row = 8'd239; row.req = r;     dir_rows.push_back(row);
		r.out_col = 9'd511; r.out_row = 8'd255; row.req = r;   dir_rows.push_back(row);
		row.typed = 0;
		r = '0; r.cmd = pnns_pkg::CMD_PAL_WRITE;
		r.palette_slot = 8'd255; r.palette_color = 16'hFFFF;
		row.req = r;                                           dir_rows.push_back(row);
		r.palette_slot = 8'd0; r.palette_color = 16'h0000; row.req = r;
		dir_rows.push_back(row);
		r = '0; r.cmd = pnns_pkg::CMD_PIX_WRITE; r.src_index = 8'd255;
		row.req = r;                                           dir_rows.push_back(row);
		r.src_col = 8'd159; r.src_row = 8'd143; row.req = r;   dir_rows.push_back(row);
		// Out-of-frame rows are dropped
		r.src_col = 8'd255; r.src_row = 8'd255; r.src_index = 8'hAA; row.req = r;
		dir_rows.push_back(row);
		r.src_row = 8'd240; row.req = r;                       dir_rows.push_back(row);
		r = '0; r.cmd = CMD_NOP; r.out_col = 9'h1FF; row.req = r; dir_rows.push_back(row);
		r = '0; r.cmd = pnns_pkg::CMD_FETCH; row.req = r;      dir_rows.push_back(row);
		r.out_col = 9'd264; r.out_row = 8'd238; row.req = r;   dir_rows.push_back(row);
		r.out_col = 9'd132; r.out_row = 8'd119; row.req = r;   dir_rows.push_back(row);
		foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// Window settings: extremes first, then random ones
		views.push_back('{9'd1, 9'd0, 9'd0, 9'd0});
		views.push_back('{9'd2, 9'd255, 9'd256, 9'd255});
		views.push_back('{9'd0, 9'd255, 9'd1, 9'd1});
		views.push_back('{9'd3, 9'd0, 9'd1, 9'd240});
		views.push_back('{9'd1, 9'd255, 9'd511, 9'd1});
		views.push_back('{9'd0, 9'd100, 9'd300, 9'd241});
		views.push_back('{9'd0, 9'd0, 9'd256, 9'd240});
		views.push_back('{9'd2, 9'd0, 9'd1, 9'd1});
		repeat (6) views.push_back('{9'($urandom_range(0, 3)), 9'($urandom_range(0, 255)),
			9'($urandom_range(0, 511)), 9'($urandom_range(0, 255))});

		foreach (views[p]) begin
			write_view(views[p]);
			no_idle = (p % 4 == 3);
			for (int k = 0; k < PER_VIEW; k++) begin
				// Hold off the result side while requests keep coming
				if (p == 2 && k == 10) long_hold = 1;
				// Pause the request side until every fetch is back
				if (p == 5 && k == 50) drain();
				if (k == 57) no_idle = !no_idle;
				r = rand_req();
				send_req(r, 0, '0);
				if (r.cmd != CMD_NOP) sent++;
			end
			drain();
		end

		$display("%0d random requests over %0d window settings, %0d pixel results checked",
			sent, views.size(), checked);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatching results", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
